### rtl/lfr_pkg.sv
`timescale 1ns / 1ps

package lfr_pkg;

	// Frame hunt phases
	typedef enum logic [1:0] {
		PH_BREAK = 2'd0,
		PH_SYNC  = 2'd1,
		PH_PID   = 2'd2,
		PH_DATA  = 2'd3
	} phase_t;

	localparam logic [7:0] BREAK_BYTE     = 8'h00;
	localparam logic [7:0] SYNC_BYTE      = 8'h55;
	localparam logic [5:0] CLASSIC_ID_MIN = 6'h3C;
	localparam int         SUM_W          = 12;

	// Checksum result passed from the checksum unit to the top level
	typedef struct packed {
		logic [7:0] computed;
		logic       ok;
	} csum_t;

endpackage

### rtl/lfr_csum.sv
`timescale 1ns / 1ps

module lfr_csum import lfr_pkg::*; (
	input  logic [SUM_W-1:0] sum,
	input  logic [7:0]       rx_byte,
	output csum_t            csum
);

	logic [8:0] fold1;
	logic [7:0] fold2;

	// End-around carry: two folds cover any sum of nine bytes.
	always_comb begin
		fold1         = {1'b0, sum[7:0]} + {5'b0, sum[SUM_W-1:8]};
		fold2         = fold1[7:0] + {7'b0, fold1[8]};
		csum.computed = ~fold2;
		csum.ok       = (rx_byte == ~fold2);
	end

endmodule

### rtl/lin_frame_receiver_top.sv
`timescale 1ns / 1ps
// Throughput: one received byte per clock cycle while the input register is not stalled.
// Result path: the checksum byte is registered in the input stage, then its frame result
//   is loaded into the result register when that stage advances.
// The input register stalls only when it holds a checksum byte and the result
//   register is still full and stalled.
// Reset (arst_n, async, active low): hunt for break, empty stages, no result.
module lin_frame_receiver_top import lfr_pkg::*; #(
	parameter int DATA_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	// frame result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  frame_id,
	output logic [7:0]  protected_id,
	output logic [63:0] frame_data,
	output logic [7:0]  received_checksum,
	output logic [7:0]  computed_checksum,
	output logic        checksum_ok
);

	localparam int IDX_W   = $clog2(DATA_BYTES + 1);
	localparam int SUM_MAX = 255 * (DATA_BYTES + 1);

	// Input stage
	logic              valid_s1;
	logic [7:0]        byte_s1;

	// Frame state
	phase_t            phase_q;
	phase_t            phase_d;
	logic [IDX_W-1:0]  byte_index_q;
	logic [7:0]        pid_q;
	logic [SUM_W-1:0]  sum_q;
	logic [7:0]        data_q [DATA_BYTES];
	logic [63:0]       packed_data;

	// Result register
	logic              out_valid_q;

	logic              load;
	logic              advance;
	logic              is_csum;
	logic              take_data;
	logic              classic;
	csum_t             csum;

	// The checksum byte is the one that follows the last data byte.
	assign is_csum   = (phase_q == PH_DATA) && (byte_index_q == IDX_W'(DATA_BYTES));
	// Hold the stage only when it would emit into a full, stalled result register.
	assign advance   = valid_s1 && !(is_csum && out_valid_q && out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign load      = in_valid && !in_stall;
	assign take_data = advance && (phase_q == PH_DATA) && !is_csum;
	assign classic   = (byte_s1[5:0] >= CLASSIC_ID_MIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= rx_byte;
		end
	end

	// Next phase: stray bytes in the hunt phases are dropped without a change.
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_BREAK, PH_SYNC: begin
				if (byte_s1 == BREAK_BYTE) begin
					phase_d = PH_SYNC;
				end else if (byte_s1 == SYNC_BYTE) begin
					phase_d = PH_PID;
				end
			end
			PH_PID: begin
				phase_d = PH_DATA;
			end
			PH_DATA: begin
				if (is_csum) begin
					phase_d = PH_BREAK;
				end
			end
			default: begin
				phase_d = PH_BREAK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_BREAK;
			byte_index_q <= '0;
			pid_q        <= '0;
			sum_q        <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			if (phase_q == PH_PID) begin
				// Enhanced checksum covers the PID, classic IDs leave it out.
				pid_q        <= byte_s1;
				sum_q        <= classic ? '0 : {{(SUM_W-8){1'b0}}, byte_s1};
				byte_index_q <= '0;
			end else if (take_data) begin
				sum_q        <= sum_q + {{(SUM_W-8){1'b0}}, byte_s1};
				byte_index_q <= IDX_W'(byte_index_q + 1'b1);
			end else if (is_csum) begin
				sum_q        <= '0;
				byte_index_q <= '0;
			end
		end
	end

	// One lane per data byte; lanes past DATA_BYTES read as zero.
	for (genvar k = 0; k < 8; k++) begin : g_lane
		if (k < DATA_BYTES) begin : g_used
			always_ff @(posedge clk) begin
				if (take_data && (byte_index_q == IDX_W'(k))) begin
					data_q[k] <= byte_s1;
				end
			end
			assign packed_data[8*k +: 8] = data_q[k];
		end else begin : g_unused
			assign packed_data[8*k +: 8] = 8'h00;
		end
	end

	lfr_csum u_csum (
		.sum     (sum_q),
		.rx_byte (byte_s1),
		.csum    (csum)
	);

	// Result register: load on the checksum byte, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_csum) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_csum) begin
			frame_id          <= pid_q[5:0];
			protected_id      <= pid_q;
			frame_data        <= packed_data;
			received_checksum <= byte_s1;
			computed_checksum <= csum.computed;
			checksum_ok       <= csum.ok;
		end
	end

	assign out_valid = out_valid_q;

	// Data counter never runs past the checksum position.
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_index_q <= IDX_W'(DATA_BYTES))
		else $error("byte index beyond data length");

	// Outside the data phase the counter is cleared.
	a_index_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_DATA) |-> (byte_index_q == '0))
		else $error("byte index not cleared outside data phase");

	// The running sum of at most DATA_BYTES + 1 bytes cannot wrap.
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= SUM_W'(SUM_MAX))
		else $error("running sum out of range");

	// A taken result with no new checksum byte leaves the register empty.
	a_out_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_stall && !(advance && is_csum)) |=> !out_valid_q)
		else $error("result not dropped after being taken");

	// A checksum byte never advances into a full, stalled result register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !(advance && is_csum))
		else $error("stalled result overwritten");

endmodule
